[rtl/i2cx_pkg.sv]
`timescale 1ns / 1ps

package i2cx_pkg;

   localparam int PinCount = 8;
   localparam logic [7:0] PortMask = 8'((9'h1 << PinCount) - 9'h1);
   localparam logic [6:0] AddrReset = 7'd32;
   localparam logic [2:0] BitCntTop = 3'd7;
   localparam logic [2:0] BitCntLast = 3'd0;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_DEVID   = 4'd1,
      PH_RETZ    = 4'd2,
      PH_ACKRD   = 4'd3,
      PH_ACKWR   = 4'd4,
      PH_WRDATA  = 4'd5,
      PH_ACKWRD  = 4'd6,
      PH_ACKNACK = 4'd7,
      PH_READ    = 4'd8
   } phase_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic       sda_pull_low;
      logic [7:0] pin_pull_low;
      logic [7:0] pin_strong_high;
      logic       intr_pull_low;
   } rsp_type;

   typedef logic [6:0] csr_type;

   typedef struct packed {
      logic    accept;
      csr_type target_address;
   } eng_ctrl_type;

endpackage

[rtl/i2cx_if.sv]
`timescale 1ns / 1ps

interface i2cx_req_if;
   import i2cx_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface i2cx_rsp_if;
   import i2cx_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface i2cx_csr_if;
   import i2cx_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

[rtl/i2cx_engine.sv]
`timescale 1ns / 1ps

module i2cx_engine
   import i2cx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  eng_ctrl_type ctrl,
   input  req_type      sample,
   output rsp_type      result
);

   logic       last_scl_ff, last_scl_in;
   logic       last_sda_ff, last_sda_in;
   logic [7:0] last_pins_ff, last_pins_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] latch_ff, latch_in;
   logic [7:0] strong_ff, strong_in;
   logic [7:0] low_ff, low_in;
   logic       sda_drv_ff, sda_drv_in;
   logic       intr_ff, intr_in;

   logic       scl, sda;
   logic [7:0] pins;
   logic       start_stop, scl_rise, scl_fall;
   logic       write_phase, raise_intr, clear_intr;

   assign scl = sample.scl_level;
   assign sda = sample.sda_level;
   assign pins = sample.pin_levels & PortMask;
   assign start_stop = scl && (sda != last_sda_ff);
   assign scl_rise = scl && !last_scl_ff;
   assign scl_fall = !scl && last_scl_ff;
   assign write_phase = (phase_ff == PH_WRDATA) || (phase_ff == PH_ACKWRD) ||
                        (phase_ff == PH_ACKWR);
   assign raise_intr = (pins != (last_pins_ff & PortMask)) && !write_phase;

   always_comb begin
      phase_in = phase_ff;
      if (start_stop) begin
         phase_in = sda ? PH_IDLE : PH_DEVID;
      end else if (scl_rise) begin
         case (phase_ff)
            PH_DEVID: begin
               if (bit_cnt_ff == BitCntLast) begin
                  if (addr_ff == ctrl.target_address) begin
                     phase_in = sda ? PH_ACKRD : PH_ACKWR;
                  end else begin
                     phase_in = PH_RETZ;
                  end
               end
            end
            PH_RETZ: phase_in = PH_IDLE;
            PH_ACKRD: phase_in = PH_READ;
            PH_ACKWR: phase_in = PH_WRDATA;
            PH_WRDATA: begin
               if (bit_cnt_ff == BitCntLast) phase_in = PH_ACKWRD;
            end
            PH_ACKWRD: phase_in = PH_WRDATA;
            PH_ACKNACK: phase_in = sda ? PH_IDLE : PH_READ;
            PH_READ: begin
               if (bit_cnt_ff == BitCntLast) phase_in = PH_ACKNACK;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      latch_in = latch_ff;
      strong_in = strong_ff;
      low_in = low_ff;
      sda_drv_in = sda_drv_ff;
      clear_intr = 1'b0;
      if (start_stop) begin
         if (!sda) begin
            bit_cnt_in = BitCntTop;
            addr_in = '0;
         end
      end else if (scl_rise) begin
         case (phase_ff)
            PH_DEVID: begin
               if (bit_cnt_ff != BitCntLast) addr_in = {addr_ff[5:0], sda};
               bit_cnt_in = bit_cnt_ff - 3'd1;
            end
            PH_ACKRD: begin
               bit_cnt_in = BitCntTop;
               data_in = pins;
               clear_intr = 1'b1;
            end
            PH_ACKWR: begin
               bit_cnt_in = BitCntTop;
               data_in = '0;
               clear_intr = 1'b1;
            end
            PH_WRDATA: begin
               data_in = {data_ff[6:0], sda};
               if (bit_cnt_ff != BitCntLast) bit_cnt_in = bit_cnt_ff - 3'd1;
            end
            PH_ACKWRD: begin
               latch_in = data_ff;
               strong_in = data_ff & PortMask;
               low_in = ~data_ff & PortMask;
               data_in = '0;
               bit_cnt_in = BitCntTop;
               clear_intr = 1'b1;
            end
            PH_ACKNACK: begin
               if (!sda) begin
                  bit_cnt_in = BitCntTop;
                  data_in = pins;
               end
            end
            PH_READ: begin
               if (bit_cnt_ff != BitCntLast) bit_cnt_in = bit_cnt_ff - 3'd1;
            end
            default: bit_cnt_in = bit_cnt_ff;
         endcase
      end else if (scl_fall) begin
         case (phase_ff)
            PH_RETZ, PH_ACKNACK: sda_drv_in = 1'b0;
            PH_ACKRD, PH_ACKWR, PH_ACKWRD: sda_drv_in = 1'b1;
            PH_WRDATA: begin
               if (bit_cnt_ff == BitCntTop) strong_in = strong_ff & ~latch_ff;
               sda_drv_in = 1'b0;
            end
            PH_READ: sda_drv_in = ~data_ff[bit_cnt_ff];
            default: sda_drv_in = sda_drv_ff;
         endcase
      end
      if (clear_intr) begin
         intr_in = 1'b0;
      end else if (raise_intr) begin
         intr_in = 1'b1;
      end else begin
         intr_in = intr_ff;
      end
      last_scl_in = scl;
      last_sda_in = sda;
      last_pins_in = pins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scl_ff <= 1'b1;
         last_sda_ff <= 1'b1;
         last_pins_ff <= 8'hFF;
         phase_ff <= PH_IDLE;
         bit_cnt_ff <= BitCntTop;
         addr_ff <= '0;
         data_ff <= '0;
         latch_ff <= '0;
         strong_ff <= '0;
         low_ff <= '0;
         sda_drv_ff <= 1'b0;
         intr_ff <= 1'b0;
      end else if (ctrl.accept) begin
         last_scl_ff <= last_scl_in;
         last_sda_ff <= last_sda_in;
         last_pins_ff <= last_pins_in;
         phase_ff <= phase_in;
         bit_cnt_ff <= bit_cnt_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
         latch_ff <= latch_in;
         strong_ff <= strong_in;
         low_ff <= low_in;
         sda_drv_ff <= sda_drv_in;
         intr_ff <= intr_in;
      end
   end

   assign result.sda_pull_low = sda_drv_in;
   assign result.pin_pull_low = low_in & PortMask;
   assign result.pin_strong_high = strong_in & PortMask;
   assign result.intr_pull_low = intr_in;

endmodule

[rtl/i2c_quasi_bidir_io_expander.sv]
`timescale 1ns / 1ps

// I2C target for an eight-pin quasi-bidirectional port. Each req beat is one
// synchronized sample of SCL, SDA and the pins; each accepted beat yields
// exactly one rsp beat with the SDA, pin and interrupt drives after that
// sample. One beat is accepted per clock: the bus state update is a single
// pass of logic from the state registers into the rsp output register, and
// req_ch.ready drops only while a held rsp beat is not taken. The answering
// address is written through csr_ch, which is always ready; write it only
// while no req beat is in flight.
module i2c_quasi_bidir_io_expander
   import i2cx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   i2cx_req_if.sink   req_ch,
   i2cx_rsp_if.source rsp_ch,
   i2cx_csr_if.sink   csr_ch
);

   csr_type      addr_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;
   rsp_type      result;
   eng_ctrl_type ctrl;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign ctrl.accept = req_ch.valid && req_ch.ready;
   assign ctrl.target_address = addr_ff;

   i2cx_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_ch.payload),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= AddrReset;
      end else if (csr_ch.valid) begin
         addr_ff <= csr_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) rsp_data_ff <= result;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule

[rtl/i2cx_checker.sv]
`timescale 1ns / 1ps

module i2cx_checker
   import i2cx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   i2cx_req_if.sink   req_ch,
   i2cx_rsp_if.source rsp_ch
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("rsp beat dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("rsp valid after reset");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> rsp_ch.valid)
      else $error("accepted req beat gave no rsp beat");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("req ready does not follow rsp slot");

   a_pin_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         (rsp_ch.payload.pin_pull_low & rsp_ch.payload.pin_strong_high) == 8'h00)
      else $error("pin driven strong high and low");

endmodule

bind i2c_quasi_bidir_io_expander i2cx_checker u_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
